FILE: src/fwad_pkg.sv
// Package for the fixed width alphabet decoder.
// Holds the phase and sequencer types and the code width function.
// No dependencies.
package fwad_pkg;

    localparam int BYTE_W  = 8;
    localparam int SIZE_W  = 9;
    localparam int WIDTH_W = 4;
    localparam int AVAIL_W = 4;
    localparam int RES_W   = 3;

    typedef enum logic [1:0] {
        PH_COUNT  = 2'd0,
        PH_TABLE  = 2'd1,
        PH_DECODE = 2'd2,
        PH_DRAIN  = 2'd3
    } t_phase;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    function automatic logic [WIDTH_W-1:0] f_code_width(input logic [SIZE_W-1:0] n);
        logic [WIDTH_W-1:0] w;
        priority if (n <= 9'd1) begin
            w = 4'd0;
        end else if (n <= 9'd2) begin
            w = 4'd1;
        end else if (n <= 9'd4) begin
            w = 4'd2;
        end else if (n <= 9'd8) begin
            w = 4'd3;
        end else if (n <= 9'd16) begin
            w = 4'd4;
        end else if (n <= 9'd32) begin
            w = 4'd5;
        end else if (n <= 9'd64) begin
            w = 4'd6;
        end else if (n <= 9'd128) begin
            w = 4'd7;
        end else begin
            w = 4'd8;
        end
        return w;
    endfunction

endpackage

FILE: src/fwad_table.sv
// Symbol table storage: one write port, one read port, registered read data.
// Read data holds until the next read. No dependencies.
module fwad_table #(
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/fixed_width_alphabet_decoder.sv
// Fixed width alphabet decoder top level; uses fwad_pkg and fwad_table.
// Header and table bytes are accepted while idle. A decode byte with k codes is
// accepted, then gets one table read per code, then hands off its last result.
// Input stalls during a run; output stall holds it. Results come via the table read port.
// Synchronous active-low reset clears control state; table contents are not cleared.
module fixed_width_alphabet_decoder
    import fwad_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_stream,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_symbol,
    output logic       o_decode_error,
    output logic       o_run_last
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [SIZE_W-1:0] DEPTH_N = SIZE_W'(TABLE_DEPTH);

    t_state               r_state, n_state;
    t_phase               r_phase, n_phase;
    logic [SIZE_W-1:0]    r_alpha, n_alpha;
    logic [SIZE_W-1:0]    r_fill, n_fill;
    logic [WIDTH_W-1:0]   r_width, n_width;
    logic [BYTE_W-1:0]    r_res_bits, n_res_bits;
    logic [RES_W-1:0]     r_res_cnt, n_res_cnt;
    logic [2*BYTE_W-1:0]  r_acc, n_acc;
    logic [AVAIL_W-1:0]   r_avail, n_avail;
    logic                 r_eos, n_eos;
    logic                 r_more, n_more;
    logic                 r_pend, n_pend;
    logic                 r_p_err, n_p_err;
    logic                 r_p_last, n_p_last;
    logic                 r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]    r_out_sym, n_out_sym;
    logic                 r_out_err, n_out_err;
    logic                 r_out_last, n_out_last;

    logic                 in_acc;
    logic                 out_free;
    logic                 fire;
    logic [AVAIL_W-1:0]   shamt;
    logic [2*BYTE_W-1:0]  shifted;
    logic [BYTE_W-1:0]    code;
    logic [AVAIL_W-1:0]   avail_left;
    logic                 code_bad;
    logic                 code_last;
    logic                 we;
    logic                 re;
    logic [BYTE_W-1:0]    rdata;
    logic [SIZE_W-1:0]    fill_inc;
    logic [SIZE_W-1:0]    cnt_n;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign fire     = (r_state == ST_RUN) && (!r_pend || out_free);

    assign shamt      = r_avail - r_width;
    assign shifted    = r_acc >> shamt;
    assign code       = shifted[BYTE_W-1:0] & BYTE_W'((9'h1 << r_width) - 9'h1);
    assign avail_left = r_avail - r_width;
    assign code_bad   = ({1'b0, code} >= r_alpha) || ({1'b0, code} >= DEPTH_N);
    assign code_last  = code_bad || (avail_left < r_width);

    assign fill_inc = r_fill + 9'd1;
    assign cnt_n    = (i_in_byte == 8'd0) ? 9'd256 : {1'b0, i_in_byte};

    assign we = in_acc && (r_phase == PH_TABLE) && (r_fill < DEPTH_N);
    assign re = fire && r_more;

    fwad_table #(
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_fill[AW-1:0]),
        .i_wdata(i_in_byte),
        .i_re   (re),
        .i_raddr(code[AW-1:0]),
        .o_rdata(rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_alpha     = r_alpha;
        n_fill      = r_fill;
        n_width     = r_width;
        n_res_bits  = r_res_bits;
        n_res_cnt   = r_res_cnt;
        n_acc       = r_acc;
        n_avail     = r_avail;
        n_eos       = r_eos;
        n_more      = r_more;
        n_pend      = r_pend;
        n_p_err     = r_p_err;
        n_p_last    = r_p_last;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_sym   = r_out_sym;
        n_out_err   = r_out_err;
        n_out_last  = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_eos = i_end_of_stream;
                    unique case (r_phase)
                        PH_COUNT: begin
                            n_alpha    = cnt_n;
                            n_width    = f_code_width(cnt_n);
                            n_fill     = '0;
                            n_res_bits = '0;
                            n_res_cnt  = '0;
                            n_phase    = PH_TABLE;
                        end
                        PH_TABLE: begin
                            n_fill = fill_inc;
                            if (fill_inc >= r_alpha) begin
                                n_res_bits = '0;
                                n_res_cnt  = '0;
                                n_phase    = PH_DECODE;
                            end
                        end
                        PH_DECODE: begin
                            if (r_width == 4'd0 || r_width > 4'd8) begin
                                n_res_bits = '0;
                                n_res_cnt  = '0;
                            end else begin
                                n_acc   = {r_res_bits, i_in_byte};
                                n_avail = {1'b0, r_res_cnt} + 4'd8;
                                n_more  = 1'b1;
                                n_pend  = 1'b0;
                                n_state = ST_RUN;
                            end
                        end
                        PH_DRAIN: begin
                        end
                        default: begin
                        end
                    endcase
                    if (i_end_of_stream && n_state == ST_IDLE) begin
                        n_phase    = PH_COUNT;
                        n_alpha    = '0;
                        n_fill     = '0;
                        n_width    = '0;
                        n_res_bits = '0;
                        n_res_cnt  = '0;
                    end
                end
            end
            ST_RUN: begin
                if (fire) begin
                    if (r_pend) begin
                        n_out_valid = 1'b1;
                        n_out_sym   = r_p_err ? 8'd0 : rdata;
                        n_out_err   = r_p_err;
                        n_out_last  = r_p_last;
                    end
                    if (r_more) begin
                        n_pend   = 1'b1;
                        n_p_err  = code_bad;
                        n_p_last = code_last;
                        n_avail  = avail_left;
                        n_more   = !code_last;
                    end else begin
                        n_pend  = 1'b0;
                        n_state = ST_IDLE;
                        if (r_p_err) begin
                            n_res_bits = '0;
                            n_res_cnt  = '0;
                            n_phase    = PH_DRAIN;
                        end else begin
                            n_res_cnt  = r_avail[RES_W-1:0];
                            n_res_bits = r_acc[BYTE_W-1:0]
                                       & BYTE_W'((9'h1 << r_avail[RES_W-1:0]) - 9'h1);
                        end
                        if (r_eos) begin
                            n_phase    = PH_COUNT;
                            n_alpha    = '0;
                            n_fill     = '0;
                            n_width    = '0;
                            n_res_bits = '0;
                            n_res_cnt  = '0;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_COUNT;
            r_alpha     <= '0;
            r_fill      <= '0;
            r_width     <= '0;
            r_res_bits  <= '0;
            r_res_cnt   <= '0;
            r_more      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_alpha     <= n_alpha;
            r_fill      <= n_fill;
            r_width     <= n_width;
            r_res_bits  <= n_res_bits;
            r_res_cnt   <= n_res_cnt;
            r_more      <= n_more;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_avail    <= n_avail;
        r_eos      <= n_eos;
        r_p_err    <= n_p_err;
        r_p_last   <= n_p_last;
        r_out_sym  <= n_out_sym;
        r_out_err  <= n_out_err;
        r_out_last <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_symbol       = r_out_sym;
    assign o_decode_error = r_out_err;
    assign o_run_last     = r_out_last;

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend)
        else $error("read pending while idle");

    a_code_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_more) |-> (r_avail >= r_width && r_width != 4'd0))
        else $error("code requested without enough bits");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_decode_error) |-> (o_symbol == 8'd0 && o_run_last))
        else $error("error result not final or symbol nonzero");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_phase == PH_DECODE && r_width != 4'd0) |=> (r_state == ST_RUN && r_more))
        else $error("decode request did not start a run");

    a_no_read_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        re |-> (r_phase == PH_DECODE))
        else $error("table read outside decode phase");

endmodule
